### src/hvt_pkg.sv
// Shared constants, state type and bin-mapping helpers for the histogram valley threshold.
// No dependencies; imported by src/histogram_valley_threshold.sv.

package hvt_pkg;

    localparam int COUNT_WIDTH = 23;
    localparam int BINS        = 256;
    localparam int BIN_W       = 8;
    localparam int PAD         = 4;
    localparam int TAPS        = 9;
    localparam int FIN_LEN     = BINS + 2 * PAD;
    localparam int K_W         = 9;
    localparam int SMOOTH_W    = COUNT_WIDTH + 7;
    localparam int PAIR_W      = COUNT_WIDTH + 1;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Kernel in hundredths, symmetric: outer, next, mid, inner, centre
    localparam logic [SMOOTH_W-1:0] TAP_OUTER  = SMOOTH_W'(5);
    localparam logic [SMOOTH_W-1:0] TAP_NEXT   = SMOOTH_W'(7);
    localparam logic [SMOOTH_W-1:0] TAP_MID    = SMOOTH_W'(10);
    localparam logic [SMOOTH_W-1:0] TAP_INNER  = SMOOTH_W'(13);
    localparam logic [SMOOTH_W-1:0] TAP_CENTRE = SMOOTH_W'(30);

    localparam logic ACT_ACCUM    = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;
    localparam logic KIND_THRESH  = 1'b0;
    localparam logic KIND_MASK    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_RUN,
        ST_DRAIN
    } hvt_state_t;

    // Map a padded position to the histogram bin it mirrors
    function automatic logic [BIN_W-1:0] bin_of(input logic [K_W-1:0] k);
        logic [K_W-1:0] t;
        if (k < K_W'(PAD))
            t = K_W'(PAD) - k;
        else if (k < K_W'(BINS + PAD))
            t = k - K_W'(PAD);
        else
            t = K_W'(2 * BINS + PAD - 2) - k;
        return t[BIN_W-1:0];
    endfunction

    // Edge bins that the finish pass replaces by fixed counts
    function automatic logic is_fixed_bin(input logic [BIN_W-1:0] b);
        return (b <= BIN_W'(2)) || (b >= BIN_W'(BINS - 3));
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] fixed_count(input logic [BIN_W-1:0] b);
        logic [COUNT_WIDTH-1:0] v;
        unique case (b)
            BIN_W'(0):        v = COUNT_WIDTH'(1);
            BIN_W'(1):        v = COUNT_WIDTH'(2);
            BIN_W'(2):        v = COUNT_WIDTH'(3);
            BIN_W'(BINS - 3): v = COUNT_WIDTH'(3);
            BIN_W'(BINS - 2): v = COUNT_WIDTH'(2);
            BIN_W'(BINS - 1): v = COUNT_WIDTH'(1);
            default:          v = '0;
        endcase
        return v;
    endfunction

endpackage

### src/histogram_valley_threshold.sv
// Valley-seeking gray-level threshold: histogram memory, smoothing pipeline, valley search.
// Depends on src/hvt_pkg.sv.
//
// Accumulate words: one per unstalled cycle, pipelined bin read-modify-write with forwarding.
// Classify words: one per unstalled cycle, result registered in the cycle after acceptance.
// Finish (accumulate with last): a wait state, then the 264 padded reads through the single
// memory read port, then the read, window, pair and sum stages produce the threshold result;
// input stalls meanwhile.
// Reset: control, valid bits and held threshold clear at once; bins read as zero until written.

module histogram_valley_threshold (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic                      action,
    input  logic [hvt_pkg::BIN_W-1:0] pixel,
    input  logic                      last,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic                      kind,
    output logic [hvt_pkg::BIN_W-1:0] threshold,
    output logic                      found,
    output logic                      mask
);
    import hvt_pkg::*;

    // ---------------------------------------------------------------- control
    hvt_state_t state_reg, state_next;
    logic [K_W-1:0] cnt_reg;
    logic issue_en;
    logic fin_done;

    logic item_acc;
    logic take_accum, take_last, take_classify;
    logic result_take;

    // ---------------------------------------------------------------- memory
    logic [COUNT_WIDTH-1:0] hist_mem [BINS];
    logic                   bin_vld_reg [BINS];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_vld_reg;
    logic [BIN_W-1:0]       mem_raddr;
    logic [COUNT_WIDTH-1:0] rd_value;

    // accumulate pipeline
    logic                   s1_valid_reg;
    logic [BIN_W-1:0]       s1_addr_reg;
    logic                   wb_valid_reg;
    logic [BIN_W-1:0]       wb_addr_reg;
    logic [COUNT_WIDTH-1:0] wb_data_reg;
    logic [COUNT_WIDTH-1:0] acc_old;
    logic [COUNT_WIDTH-1:0] acc_new;

    // finish pipeline
    logic                   d_valid_reg;
    logic [K_W-1:0]         d_k_reg;
    logic [BIN_W-1:0]       d_bin;
    logic [COUNT_WIDTH-1:0] pad_value;
    logic [COUNT_WIDTH-1:0] cap_hi_reg;   // bin BINS-4
    logic [COUNT_WIDTH-1:0] cap_lo_reg;   // bin BINS-5

    logic [COUNT_WIDTH-1:0] win_reg [TAPS];
    logic                   w_valid_reg;
    logic [K_W-1:0]         w_k_reg;

    logic                   p_valid_reg;
    logic [BIN_W-1:0]       p_idx_reg;
    logic [PAIR_W-1:0]      ps_outer_reg, ps_next_reg, ps_mid_reg, ps_inner_reg;
    logic [COUNT_WIDTH-1:0] centre_reg;

    logic                   s_valid_reg;
    logic [BIN_W-1:0]       s_idx_reg;
    logic [SMOOTH_W-1:0]    sm_reg;
    logic [SMOOTH_W-1:0]    weighted;

    logic [SMOOTH_W-1:0]    prev1_reg, prev2_reg;
    logic                   fnd_reg;
    logic [BIN_W-1:0]       cand_reg;
    logic                   hit;
    logic                   fin_found;
    logic [BIN_W-1:0]       fin_thr;

    // ---------------------------------------------------------------- result
    logic                   result_valid_reg;
    logic                   kind_reg;
    logic [BIN_W-1:0]       threshold_reg;
    logic                   found_reg;
    logic                   mask_reg;
    logic [BIN_W-1:0]       held_reg;

    // Stall while finishing, or while a result still waits downstream
    assign item_stall    = (state_reg != ST_IDLE) || (result_valid_reg && result_stall);
    assign item_acc      = item_valid && !item_stall;
    assign take_accum    = item_acc && (action == ACT_ACCUM);
    assign take_last     = take_accum && last;
    assign take_classify = item_acc && (action == ACT_CLASSIFY);
    assign result_take   = result_valid_reg && !result_stall;

    // ---------------------------------------------------------------- state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_WAIT)
                cnt_reg <= '0;
            else if (issue_en)
                cnt_reg <= cnt_reg + K_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        issue_en   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_last)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                // let the last pixel's write-back land before the sweep reads
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                issue_en = 1'b1;
                if (cnt_reg == K_W'(FIN_LEN - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (fin_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- bin memory
    assign mem_raddr = issue_en ? bin_of(cnt_reg) : pixel;
    assign rd_value  = rd_vld_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            hist_mem[s1_addr_reg] <= acc_new;
        rd_data_reg <= hist_mem[mem_raddr];
    end

    // Valid bits stand in for a cleared memory; drop them all when the pass ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg <= '{default: 1'b0};
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= bin_vld_reg[mem_raddr];
            if (fin_done)
                bin_vld_reg <= '{default: 1'b0};
            else if (s1_valid_reg)
                bin_vld_reg[s1_addr_reg] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- accumulate
    // Forward the previous write-back when it hit the same bin after our read
    assign acc_old = (wb_valid_reg && (wb_addr_reg == s1_addr_reg)) ? wb_data_reg : rd_value;
    assign acc_new = (acc_old == CNT_MAX) ? acc_old : acc_old + COUNT_WIDTH'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take_accum;
            wb_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= pixel;
        wb_addr_reg <= s1_addr_reg;
        wb_data_reg <= acc_new;
    end

    // ---------------------------------------------------------------- padded stream
    assign d_bin = bin_of(d_k_reg);

    always_comb
    begin
        if (is_fixed_bin(d_bin))
            pad_value = fixed_count(d_bin);
        else if (d_k_reg >= K_W'(BINS + PAD))
            pad_value = (d_bin == BIN_W'(BINS - 4)) ? cap_hi_reg : cap_lo_reg;
        else
            pad_value = rd_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            w_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= issue_en;
            w_valid_reg <= d_valid_reg;
            p_valid_reg <= w_valid_reg && (w_k_reg >= K_W'(TAPS - 1));
            s_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_k_reg <= cnt_reg;
        if (d_valid_reg && (d_k_reg < K_W'(BINS + PAD)))
        begin
            // hold the right-edge bins that the mirror padding revisits
            if (d_bin == BIN_W'(BINS - 4))
                cap_hi_reg <= rd_value;
            if (d_bin == BIN_W'(BINS - 5))
                cap_lo_reg <= rd_value;
        end
        if (d_valid_reg)
        begin
            win_reg[0] <= pad_value;
            for (int j = 1; j < TAPS; j++)
                win_reg[j] <= win_reg[j-1];
        end
        w_k_reg <= d_k_reg;

        // fold the symmetric kernel into pair sums
        ps_outer_reg <= PAIR_W'(win_reg[0]) + PAIR_W'(win_reg[8]);
        ps_next_reg  <= PAIR_W'(win_reg[1]) + PAIR_W'(win_reg[7]);
        ps_mid_reg   <= PAIR_W'(win_reg[2]) + PAIR_W'(win_reg[6]);
        ps_inner_reg <= PAIR_W'(win_reg[3]) + PAIR_W'(win_reg[5]);
        centre_reg   <= win_reg[4];
        p_idx_reg    <= BIN_W'(w_k_reg - K_W'(TAPS - 1));

        sm_reg    <= weighted;
        s_idx_reg <= p_idx_reg;
    end

    assign weighted = SMOOTH_W'(ps_outer_reg) * TAP_OUTER
                    + SMOOTH_W'(ps_next_reg)  * TAP_NEXT
                    + SMOOTH_W'(ps_mid_reg)   * TAP_MID
                    + SMOOTH_W'(ps_inner_reg) * TAP_INNER
                    + SMOOTH_W'(centre_reg)   * TAP_CENTRE;

    // ---------------------------------------------------------------- valley search
    // Strict minimum at index-1; later hits overwrite so the highest index wins
    assign hit       = s_valid_reg && (s_idx_reg >= BIN_W'(2))
                       && (prev2_reg > prev1_reg) && (prev1_reg < sm_reg);
    assign fin_found = fnd_reg || hit;
    assign fin_thr   = hit ? (s_idx_reg - BIN_W'(1)) : cand_reg;
    assign fin_done  = s_valid_reg && (s_idx_reg == BIN_W'(BINS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fnd_reg <= 1'b0;
        end
        else if (state_reg == ST_WAIT)
        begin
            fnd_reg <= 1'b0;
        end
        else if (hit)
        begin
            fnd_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid_reg)
        begin
            prev2_reg <= prev1_reg;
            prev1_reg <= sm_reg;
        end
        if (hit)
            cand_reg <= s_idx_reg - BIN_W'(1);
    end

    // ---------------------------------------------------------------- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            held_reg         <= '0;
        end
        else
        begin
            if (take_classify || fin_done)
                result_valid_reg <= 1'b1;
            else if (result_take)
                result_valid_reg <= 1'b0;
            if (fin_done && fin_found)
                held_reg <= fin_thr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_classify)
        begin
            kind_reg      <= KIND_MASK;
            threshold_reg <= held_reg;
            found_reg     <= 1'b0;
            mask_reg      <= (pixel < held_reg);
        end
        else if (fin_done)
        begin
            kind_reg      <= KIND_THRESH;
            threshold_reg <= fin_found ? fin_thr : held_reg;
            found_reg     <= fin_found;
            mask_reg      <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign threshold    = threshold_reg;
    assign found        = found_reg;
    assign mask         = mask_reg;

    // ---------------------------------------------------------------- assertions
    a_classify_result: assert property (@(posedge clk) disable iff (!rst_n)
        take_classify |=> (result_valid && (kind == KIND_MASK)))
        else $error("classify word produced no mask result");

    a_last_starts_finish: assert property (@(posedge clk) disable iff (!rst_n)
        take_last |=> (state_reg == ST_WAIT))
        else $error("last pixel did not start the finish pass");

    a_no_writeback_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !s1_valid_reg)
        else $error("accumulate write-back overlaps the finish sweep");

    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        fin_done |=> (result_valid && (kind == KIND_THRESH) && (state_reg == ST_IDLE)))
        else $error("finish pass ended without a threshold result");

endmodule
